/* hw/rtl/av1shl_pkg.sv */
package av1shl_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 1048576;
  localparam int unsigned MAX_SIZE_BYTES   = 8;

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned END_W = POS_W + 1;
  localparam int unsigned ACC_W = 7 * MAX_SIZE_BYTES;
  localparam int unsigned CNT_W = $clog2(MAX_SIZE_BYTES + 1);
  localparam int unsigned EXT_W = ACC_W + POS_W;

  localparam int unsigned HEND_W = 21;

  localparam logic [3:0] TYPE_SEQ_HDR   = 4'd1;
  localparam logic [3:0] TYPE_FRAME_HDR = 4'd3;
  localparam logic [3:0] TYPE_FRAME     = 4'd6;

  localparam logic [7:0] LEB_MASK = 8'h7F;
  localparam logic [7:0] LEB_MORE = 8'h80;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_EXT    = 2'd1,
    PH_SIZE   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    DEC_NONE   = 2'd0,
    DEC_SEQ    = 2'd1,
    DEC_NOSIZE = 2'd2,
    DEC_FRAME  = 2'd3
  } dec_e;

  typedef enum logic [1:0] {
    CAUSE_SEQ    = 2'd0,
    CAUSE_NOSIZE = 2'd1,
    CAUSE_FRAME  = 2'd2,
    CAUSE_END    = 2'd3
  } cause_e;

  typedef struct packed {
    logic               found;
    logic [HEND_W-1:0]  header_end;
    cause_e             stop_cause;
  } res_t;

  // end offset of an obu, saturated: a size too large for the position range reads as all ones
  function automatic logic [END_W-1:0] sat_end(input logic [POS_W-1:0] base,
                                               input logic [ACC_W-1:0] acc);
    logic [EXT_W-1:0] wide;
    logic [END_W-1:0] sum;
    wide = EXT_W'(acc);
    sum  = END_W'(base) + END_W'(wide[POS_W-1:0]);
    if (|wide[EXT_W-1:POS_W]) begin
      sat_end = '1;
    end else begin
      sat_end = sum;
    end
  endfunction

endpackage

/* hw/rtl/av1shl_in_if.sv */
interface av1shl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hw/rtl/av1shl_out_if.sv */
interface av1shl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [20:0] header_end;
  logic [1:0]  stop_cause;

  modport source (output valid, output found, output header_end, output stop_cause,
                  input ready);
  modport sink (input valid, input found, input header_end, input stop_cause,
                output ready);
endinterface

/* hw/rtl/av1shl_parser.sv */
module av1shl_parser
  import av1shl_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  av1shl_in_if.sink      in_i,
  input  logic           space_i,
  output logic           push_o,
  output res_t           res_o
);

  logic [POS_W-1:0] pos_q, pos_d, pos_s;
  phase_e           phase_q, phase_d, phase_s;
  logic [3:0]       type_q, type_d, type_s;
  logic [ACC_W-1:0] acc_q, acc_d, acc_s, acc_new;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_s, cnt_inc;
  logic [END_W-1:0] nhp_q, nhp_d, nhp_s, nhp_f;
  dec_e             dec_q, dec_d, dec_s, dec_f;

  logic             accept;
  logic             in_range;
  logic             can_look;
  logic             size_open;
  logic             step_done;
  logic [END_W-1:0] step_end;
  logic [END_W-1:0] fin_end;
  logic [7:0]       b;

  assign in_i.ready = space_i;
  assign accept     = in_i.valid && space_i;
  assign b          = in_i.data_byte;

  // next state
  always_comb begin
    in_range  = pos_q < POS_W'(MAX_PACKET_BYTES);
    can_look  = !in_i.last_byte && (POS_W'(pos_q + 1'b1) < POS_W'(MAX_PACKET_BYTES));
    size_open = cnt_q < CNT_W'(MAX_SIZE_BYTES);
    cnt_inc   = cnt_q + CNT_W'(1);
    acc_new   = acc_q | (ACC_W'(b & LEB_MASK) << (7 * cnt_q));
    step_end  = size_open ? sat_end(POS_W'(pos_q + 1'b1), acc_new) : sat_end(pos_q, acc_q);
    step_done = 1'b0;

    pos_s   = pos_q;
    phase_s = phase_q;
    type_s  = type_q;
    acc_s   = acc_q;
    cnt_s   = cnt_q;
    nhp_s   = nhp_q;
    dec_s   = dec_q;

    if (accept && in_range) begin
      pos_s = POS_W'(pos_q + 1'b1);
      case (phase_q)
        PH_HEADER: begin
          if (END_W'(pos_q) == nhp_q && can_look) begin
            if (!b[1]) begin
              dec_s   = DEC_NOSIZE;
              phase_s = PH_DONE;
            end else begin
              type_s  = b[6:3];
              acc_s   = '0;
              cnt_s   = '0;
              phase_s = b[2] ? PH_EXT : PH_SIZE;
            end
          end
        end
        PH_EXT: begin
          phase_s = PH_SIZE;
        end
        PH_SIZE: begin
          if (size_open) begin
            acc_s = acc_new;
            cnt_s = cnt_inc;
            if (!(|(b & LEB_MORE)) || cnt_inc >= CNT_W'(MAX_SIZE_BYTES)) begin
              step_done = 1'b1;
            end
          end else begin
            step_done = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (step_done) begin
      if (type_q == TYPE_SEQ_HDR) begin
        dec_s   = DEC_SEQ;
        nhp_s   = step_end;
        phase_s = PH_DONE;
      end else if (type_q == TYPE_FRAME || type_q == TYPE_FRAME_HDR) begin
        dec_s   = DEC_FRAME;
        phase_s = PH_DONE;
      end else begin
        nhp_s   = step_end;
        phase_s = PH_HEADER;
      end
    end

    // packet end closes an obu still in its header
    fin_end = sat_end(pos_s, acc_s);
    dec_f   = dec_s;
    nhp_f   = nhp_s;
    if (phase_s == PH_EXT || phase_s == PH_SIZE) begin
      if (type_s == TYPE_SEQ_HDR) begin
        dec_f = DEC_SEQ;
        nhp_f = fin_end;
      end else if (type_s == TYPE_FRAME || type_s == TYPE_FRAME_HDR) begin
        dec_f = DEC_FRAME;
      end else begin
        nhp_f = fin_end;
      end
    end

    if (accept && in_i.last_byte) begin
      pos_d   = '0;
      phase_d = PH_HEADER;
      type_d  = '0;
      acc_d   = '0;
      cnt_d   = '0;
      nhp_d   = '0;
      dec_d   = DEC_NONE;
    end else begin
      pos_d   = pos_s;
      phase_d = phase_s;
      type_d  = type_s;
      acc_d   = acc_s;
      cnt_d   = cnt_s;
      nhp_d   = nhp_s;
      dec_d   = dec_s;
    end
  end

  // outputs
  always_comb begin
    push_o           = accept && in_i.last_byte;
    res_o.found      = (dec_f == DEC_SEQ) && (nhp_f != '0) && (nhp_f <= END_W'(pos_s));
    res_o.header_end = res_o.found ? HEND_W'(nhp_f) : '0;
    case (dec_f)
      DEC_SEQ:    res_o.stop_cause = CAUSE_SEQ;
      DEC_NOSIZE: res_o.stop_cause = CAUSE_NOSIZE;
      DEC_FRAME:  res_o.stop_cause = CAUSE_FRAME;
      default:    res_o.stop_cause = CAUSE_END;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_HEADER;
      type_q  <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      nhp_q   <= '0;
      dec_q   <= DEC_NONE;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      type_q  <= type_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      nhp_q   <= nhp_d;
      dec_q   <= dec_d;
    end
  end

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (pos_q == '0 && phase_q == PH_HEADER && dec_q == DEC_NONE))
    else $error("parser did not restart after packet end");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_PACKET_BYTES))
    else $error("byte position past packet limit");

  a_done_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> (dec_q != DEC_NONE))
    else $error("scan stopped without a decision");

endmodule

/* hw/rtl/av1shl_out_reg.sv */
module av1shl_out_reg
  import av1shl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  res_t         res_i,
  output logic         space_o,
  av1shl_out_if.source out_o
);

  logic valid_q, valid_d;
  res_t res_q, res_d;

  assign space_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid      = valid_q;
  assign out_o.found      = res_q.found;
  assign out_o.header_end = res_q.header_end;
  assign out_o.stop_cause = res_q.stop_cause;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("result pushed into a full output stage");

  a_found_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found) |-> (out_o.stop_cause == CAUSE_SEQ && out_o.header_end != '0))
    else $error("found result with inconsistent fields");

  a_nofound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |-> (out_o.header_end == '0))
    else $error("header end set without a found header");

endmodule

/* hw/rtl/av1_sequence_header_locator_top.sv */
// av1 sequence header locator
// in_i carries the bytes of one low-overhead keyframe packet, one per transfer,
// with last_byte set on the final byte. the block walks the obu headers and
// stops at a sequence header, a frame or frame header, or a header without
// a size field. out_o carries one result transfer per packet: found,
// header_end (offset just past the sequence header) and stop_cause.
// throughput: one byte per cycle; each byte is a single state update in the
// parser registers, with no stall of its own.
// latency: the result is valid in the cycle after the last byte transfer.
// the result sits in a single output register; in_i.ready is high while that
// register is empty or being drained, so a stalled receiver holds the result
// and back-pressures the byte stream only while a result is waiting.
// reset: asynchronous, active low; the parser returns to the start of a
// packet and the output register is emptied. the parser also returns to the
// start on its own after every last byte.
module av1_sequence_header_locator_top
  import av1shl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  av1shl_in_if.sink    in_i,
  av1shl_out_if.source out_o
);

  logic space;
  logic push;
  res_t res;

  av1shl_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .space_i (space),
    .push_o  (push),
    .res_o   (res)
  );

  av1shl_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

/* dv/testbench.sv */
package obu_scan_pkg;
  import av1shl_pkg::*;

  class seq_header_search;
    int unsigned     pos;
    phase_e          phase;
    logic [3:0]      obu_kind;
    longint unsigned leb_value;
    int unsigned     leb_count;
    longint unsigned mark;
    dec_e            verdict;
    res_t            due_reports[$];
    int unsigned     n_bad;

    function new();
      n_bad = 0;
      restart();
    endfunction

    function void restart();
      pos       = 0;
      phase     = PH_HEADER;
      obu_kind  = '0;
      leb_value = 0;
      leb_count = 0;
      mark      = 0;
      verdict   = DEC_NONE;
    endfunction

    function void close_obu(longint unsigned obu_end);
      if (obu_kind == TYPE_SEQ_HDR) begin
        verdict = DEC_SEQ;
        mark    = obu_end;
        phase   = PH_DONE;
      end else if (obu_kind == TYPE_FRAME || obu_kind == TYPE_FRAME_HDR) begin
        verdict = DEC_FRAME;
        phase   = PH_DONE;
      end else begin
        mark  = obu_end;
        phase = PH_HEADER;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      longint unsigned p;
      longint unsigned chunk;
      res_t rep;
      p = pos;
      if (p < MAX_PACKET_BYTES) begin
        case (phase)
          PH_HEADER: begin
            // a header on the final byte is never looked at
            if (p == mark && !last && p + 1 < MAX_PACKET_BYTES) begin
              if (!b[1]) begin
                verdict = DEC_NOSIZE;
                phase   = PH_DONE;
              end else begin
                obu_kind  = b[6:3];
                leb_value = 0;
                leb_count = 0;
                phase     = b[2] ? PH_EXT : PH_SIZE;
              end
            end
          end
          PH_EXT: phase = PH_SIZE;
          PH_SIZE: begin
            if (leb_count < MAX_SIZE_BYTES) begin
              chunk = b & LEB_MASK;
              leb_value |= chunk << (7 * leb_count);
              leb_count++;
              if ((b & LEB_MORE) == 0 || leb_count >= MAX_SIZE_BYTES) begin
                close_obu(p + 1 + leb_value);
              end
            end else begin
              close_obu(p + leb_value);
            end
          end
          default: ;
        endcase
        pos = p + 1;
      end
      if (last) begin
        // size cut short by the end of the packet: the partial value counts
        if (phase == PH_EXT || phase == PH_SIZE) begin
          close_obu(pos + leb_value);
        end
        rep = '0;
        rep.stop_cause = CAUSE_END;
        if (verdict == DEC_SEQ) begin
          rep.stop_cause = CAUSE_SEQ;
          if (mark > 0 && mark <= pos) begin
            rep.found      = 1'b1;
            rep.header_end = mark[HEND_W-1:0];
          end
        end else if (verdict == DEC_NOSIZE) begin
          rep.stop_cause = CAUSE_NOSIZE;
        end else if (verdict == DEC_FRAME) begin
          rep.stop_cause = CAUSE_FRAME;
        end
        due_reports = {due_reports, rep};
        restart();
      end
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (due_reports.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("unexpected report: found=%0b end=%0d cause=%0d",
                   got.found, got.header_end, got.stop_cause);
        end
        return;
      end
      want = due_reports[0];
      due_reports.delete(0);
      if (got.found !== want.found || got.header_end !== want.header_end ||
          got.stop_cause !== want.stop_cause) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("mismatch: exp found=%0b end=%0d cause=%0d, got found=%0b end=%0d cause=%0d",
                   want.found, want.header_end, want.stop_cause,
                   got.found, got.header_end, got.stop_cause);
        end
      end
    endfunction
  endclass

endpackage

module testbench
  import av1shl_pkg::*, obu_scan_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RANDOM_BYTES = 800;
  localparam int unsigned LONG_HOLD    = 150;

  typedef enum int unsigned {LEB_SHORT, LEB_PADDED, LEB_OPEN, LEB_JUNK} leb_form_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  av1shl_in_if  byte_if ();
  av1shl_out_if report_if ();

  seq_header_search search;
  logic [7:0]       pkt[$];
  int unsigned      idle_max    = 7;
  int unsigned      hold_off    = 0;
  int unsigned      cycle_count = 0;

  av1_sequence_header_locator_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (report_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    search.take_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) begin
      send_byte(pkt[i], i == pkt.size() - 1, $urandom_range(0, idle_max));
    end
  endtask

  task automatic wait_drain();
    byte_if.valid <= 1'b0;
    do @(negedge clk_i); while (search.due_reports.size() != 0);
  endtask

  function automatic leb_form_e pick_form();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 13) return LEB_SHORT;
    if (r < 17) return LEB_PADDED;
    if (r < 19) return LEB_OPEN;
    return LEB_JUNK;
  endfunction

  function automatic int unsigned pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(128, 300);
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [3:0] plain_kind();
    logic [3:0] k;
    do k = 4'($urandom); while (k == TYPE_SEQ_HDR || k == TYPE_FRAME || k == TYPE_FRAME_HDR);
    return k;
  endfunction

  function automatic void add_obu(input logic [3:0] kind, input int unsigned len,
                                  input leb_form_e form);
    bit          ext;
    int unsigned n;
    int unsigned cnt;
    logic [7:0]  v;
    ext = $urandom_range(0, 1);
    pkt = {pkt, {1'($urandom), kind, ext, 1'b1, 1'($urandom)}};
    if (ext) pkt = {pkt, 8'($urandom)};
    n = 1;
    while (n < MAX_SIZE_BYTES && (len >> (7 * n)) != 0) n++;
    if (form == LEB_PADDED) begin
      n = (n + 3 > MAX_SIZE_BYTES) ? MAX_SIZE_BYTES : n + $urandom_range(1, 3);
    end
    cnt = (form == LEB_OPEN || form == LEB_JUNK) ? MAX_SIZE_BYTES : n;
    for (int i = 0; i < cnt; i++) begin
      if (form == LEB_OPEN) begin
        v = LEB_MORE | ((i == 0) ? (8'(len) & LEB_MASK) : 8'h00);
      end else if (form == LEB_JUNK) begin
        v = LEB_MORE | 8'($urandom);
      end else begin
        v = (8'(len >> (7 * i)) & LEB_MASK) | ((i < cnt - 1) ? LEB_MORE : 8'h00);
      end
      pkt = {pkt, v};
    end
    if (form != LEB_JUNK) begin
      repeat (len) pkt = {pkt, 8'($urandom)};
    end
  endfunction

  function automatic void build_packet();
    int unsigned style;
    int unsigned cut;
    pkt.delete();
    style = $urandom_range(0, 19);
    if (style < 3) begin
      repeat ($urandom_range(1, 12)) pkt = {pkt, 8'($urandom)};
    end else begin
      repeat ($urandom_range(0, 3)) add_obu(plain_kind(), pick_len(), pick_form());
      case ($urandom_range(0, 5))
        0, 1, 2: add_obu(TYPE_SEQ_HDR, $urandom_range(0, 12), pick_form());
        3: add_obu($urandom_range(0, 1) ? TYPE_FRAME : TYPE_FRAME_HDR, pick_len(), pick_form());
        4: pkt = {pkt, {1'($urandom), 4'($urandom), 1'($urandom), 1'b0, 1'($urandom)}};
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) pkt = {pkt, 8'($urandom)};
      // broken packet: cut off somewhere inside
      if (style < 6 && pkt.size() > 1) begin
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
    end
    if (pkt.size() == 0) pkt = {pkt, 8'($urandom)};
  endfunction

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : report_sink
    int unsigned stall;
    res_t        got;
    report_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, idle_max);
      if (hold_off > 0) begin
        stall    = hold_off;
        hold_off = 0;
      end
      if (stall > 0) begin
        report_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      report_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!report_if.valid) @(posedge clk_i);
      got.found      = report_if.found;
      got.header_end = report_if.header_end;
      got.stop_cause = cause_e'(report_if.stop_cause);
      search.check_report(got);
    end
  end

  initial begin : byte_source
    int unsigned sent;
    search            = new();
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // header on the only byte
    pkt = '{8'h0A};
    send_packet();
    // empty sequence header
    pkt = '{8'h0A, 8'h00, 8'h00};
    send_packet();
    // no size field
    pkt = '{8'h08, 8'hFF};
    send_packet();
    pkt = '{8'h32, 8'h00, 8'h00};
    send_packet();
    // extension byte, size cut short by the end of the packet
    pkt = '{8'h0E, 8'h5A, 8'h85};
    send_packet();
    // sequence header ending past the packet
    pkt = '{8'h0A, 8'h01};
    send_packet();
    // size with no terminator, then a frame header
    pkt = '{8'h12, 8'h81, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
            8'h00, 8'h1A, 8'h00};
    send_packet();
    pkt = '{8'hFF, 8'hFF, 8'h00, 8'hFF};
    send_packet();

    // hold the result side while packets keep coming
    wait_drain();
    hold_off = LONG_HOLD;
    idle_max = 0;
    repeat (6) begin
      build_packet();
      send_packet();
    end
    idle_max = 7;
    wait_drain();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) idle_max = (idle_max == 0) ? 7 : 0;
      if ($urandom_range(0, 29) == 0) wait_drain();
      build_packet();
      sent += pkt.size();
      send_packet();
    end
    wait_drain();
    repeat (10) @(posedge clk_i);
    if (search.n_bad == 0 && search.due_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
